// ===== rtl/amou_pkg.sv =====
package amou_pkg;

  localparam int ADDR_W = 11;
  localparam int DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Action codes
  localparam logic [3:0] ACT_LR   = 4'd0;
  localparam logic [3:0] ACT_SC   = 4'd1;
  localparam logic [3:0] ACT_SWAP = 4'd2;
  localparam logic [3:0] ACT_ADD  = 4'd3;
  localparam logic [3:0] ACT_XOR  = 4'd4;
  localparam logic [3:0] ACT_AND  = 4'd5;
  localparam logic [3:0] ACT_OR   = 4'd6;
  localparam logic [3:0] ACT_MIN  = 4'd7;
  localparam logic [3:0] ACT_MAX  = 4'd8;
  localparam logic [3:0] ACT_MINU = 4'd9;
  localparam logic [3:0] ACT_MAXU = 4'd10;

  // Fault codes
  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_ILLEGAL    = 2'd1;
  localparam logic [1:0] FAULT_MISALIGNED = 2'd2;
  localparam logic [1:0] FAULT_ACCESS     = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ATOMICS_ENABLE    = 3'd0;
  localparam logic [2:0] REG_DOUBLEWORD_ENABLE = 3'd1;
  localparam logic [2:0] REG_MISALIGNED_AS_AF  = 3'd2;
  localparam logic [2:0] REG_LOCAL_ONLY        = 3'd3;
  localparam logic [2:0] REG_LOCAL_BASE        = 3'd4;
  localparam logic [2:0] REG_LOCAL_LIMIT       = 3'd5;

  typedef struct packed {
    logic [3:0]        action;
    logic              is_double;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] operand;
  } amou_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_value;
    logic              rd_written;
    logic [1:0]        fault;
  } amou_rsp_t;

endpackage

// ===== rtl/atomic_memory_op_unit.sv =====
// Atomic memory operation unit (LR, SC and AMO read-modify-write).
// The store is read on the accept edge; modify and write-back happen on the edge that
// completes the request in the execute state, which also loads the response register.
// One request at a time: a new request is not taken until the one in flight completes; a stalled
// response holds the request in flight and keeps the request side closed.
// Reset: synchronous, active high; registers return to their reset values, the reservation
// clears, and a clearing sweep zeroes every store entry before any request is taken.
module atomic_memory_op_unit #(
  parameter int MEM_WORDS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  amou_pkg::amou_req_t                  req,
  // response channel
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output amou_pkg::amou_rsp_t                  rsp,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [amou_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [amou_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [amou_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  // Number of distinct doubleword slots an address can name.
  localparam int SLOTS = 2 ** (amou_pkg::ADDR_W - 3);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Configuration registers
  logic                        atomics_enable;
  logic                        doubleword_enable;
  logic                        misaligned_as_access_fault;
  logic                        local_only;
  logic [amou_pkg::ADDR_W-1:0] local_base;
  logic [amou_pkg::ADDR_W-1:0] local_limit;

  // Reservation
  logic                        reservation_valid;
  logic [amou_pkg::ADDR_W-1:0] reservation_address;
  logic                        reservation_double;

  // Request in flight and clearing sweep pointer
  amou_pkg::amou_req_t cur;
  logic [IDX_W-1:0]    clr_idx;

  // Data store: one write port, one registered read port
  logic [amou_pkg::DATA_W-1:0] mem [MEM_WORDS];
  logic [amou_pkg::DATA_W-1:0] rdata;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [amou_pkg::DATA_W-1:0] mem_wdata;

  // Slot number modulo MEM_WORDS, as a constant lookup table built at elaboration.
  logic [IDX_W-1:0] idx_tab [SLOTS];
  for (genvar g = 0; g < SLOTS; g++) begin : g_idx_tab
    assign idx_tab[g] = IDX_W'(g % MEM_WORDS);
  end

  logic [IDX_W-1:0] req_idx;
  logic [IDX_W-1:0] cur_idx;
  assign req_idx = idx_tab[req.address[amou_pkg::ADDR_W-1:3]];
  assign cur_idx = idx_tab[cur.address[amou_pkg::ADDR_W-1:3]];

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic req_fire;
  logic finish;
  logic cfg_write;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  // Complete the request in flight only when the response register is free.
  assign finish    = (state == ST_EXEC) && (!rsp_valid || rsp_ready);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // ---------------------------------------------------------------------------
  // Execute: fault check, read-modify-write datapath, reservation update
  // ---------------------------------------------------------------------------
  logic [1:0]                  fault;
  logic                        illegal;
  logic                        misaligned;
  logic                        outside;
  logic                        is_sc;
  logic                        sc_hit;
  logic [amou_pkg::DATA_W-1:0] raw;
  logic [amou_pkg::DATA_W-1:0] old_val;
  logic [amou_pkg::DATA_W-1:0] src_val;
  logic [amou_pkg::DATA_W-1:0] res_val;
  logic [amou_pkg::DATA_W-1:0] store_val;
  logic                        do_write;
  amou_pkg::amou_rsp_t         rsp_next;
  logic                        resv_clear;
  logic                        resv_set;

  always_comb begin
    illegal    = !atomics_enable || (cur.action > amou_pkg::ACT_MAXU) ||
                 (cur.is_double && !doubleword_enable);
    misaligned = cur.is_double ? (cur.address[2:0] != 3'd0) : (cur.address[1:0] != 2'd0);
    // The window check looks at the start address only.
    outside    = local_only && ((cur.address < local_base) || (cur.address > local_limit));

    if (illegal) begin
      fault = amou_pkg::FAULT_ILLEGAL;
    end else if (misaligned) begin
      fault = misaligned_as_access_fault ? amou_pkg::FAULT_ACCESS : amou_pkg::FAULT_MISALIGNED;
    end else if (outside) begin
      fault = amou_pkg::FAULT_ACCESS;
    end else begin
      fault = amou_pkg::FAULT_NONE;
    end

    is_sc  = (cur.action == amou_pkg::ACT_SC);
    sc_hit = reservation_valid && (reservation_address == cur.address) &&
             (reservation_double == cur.is_double);

    // Select the addressed half for a word access and sign-extend.
    if (cur.is_double) begin
      raw = rdata;
    end else if (cur.address[2]) begin
      raw = {32'd0, rdata[63:32]};
    end else begin
      raw = {32'd0, rdata[31:0]};
    end
    old_val = cur.is_double ? raw : {{32{raw[31]}}, raw[31:0]};
    src_val = cur.is_double ? cur.operand : {{32{cur.operand[31]}}, cur.operand[31:0]};

    // Both operands are sign-extended for words, so 64-bit compares give word order too.
    case (cur.action)
      amou_pkg::ACT_SWAP: res_val = src_val;
      amou_pkg::ACT_ADD:  res_val = src_val + old_val;
      amou_pkg::ACT_XOR:  res_val = src_val ^ old_val;
      amou_pkg::ACT_AND:  res_val = src_val & old_val;
      amou_pkg::ACT_OR:   res_val = src_val | old_val;
      amou_pkg::ACT_MIN:  res_val = ($signed(src_val) < $signed(old_val)) ? src_val : old_val;
      amou_pkg::ACT_MAX:  res_val = ($signed(old_val) < $signed(src_val)) ? src_val : old_val;
      amou_pkg::ACT_MINU: res_val = (src_val < old_val) ? src_val : old_val;
      amou_pkg::ACT_MAXU: res_val = (src_val > old_val) ? src_val : old_val;
      default:            res_val = old_val;
    endcase
    if (is_sc) begin
      res_val = cur.operand;
    end

    // Merge a word result into the untouched half.
    if (cur.is_double) begin
      store_val = res_val;
    end else if (cur.address[2]) begin
      store_val = {res_val[31:0], rdata[31:0]};
    end else begin
      store_val = {rdata[63:32], res_val[31:0]};
    end

    do_write = (fault == amou_pkg::FAULT_NONE) &&
               (is_sc ? sc_hit : (cur.action != amou_pkg::ACT_LR));

    rsp_next.fault      = fault;
    rsp_next.rd_written = (fault == amou_pkg::FAULT_NONE);
    if (fault != amou_pkg::FAULT_NONE) begin
      rsp_next.rd_value = '0;
    end else if (is_sc) begin
      rsp_next.rd_value = {63'd0, !sc_hit};
    end else begin
      rsp_next.rd_value = old_val;
    end

    // Every SC that gets past the illegal check drops the reservation; a clean LR sets it.
    resv_clear = is_sc && !illegal;
    resv_set   = (cur.action == amou_pkg::ACT_LR) && (fault == amou_pkg::FAULT_NONE);
  end

  // ---------------------------------------------------------------------------
  // Memory port control
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_re    = req_fire;
    mem_raddr = req_idx;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else begin
      mem_we    = finish && do_write;
      mem_waddr = cur_idx;
      mem_wdata = store_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, reservation, response register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLEAR;
      clr_idx             <= '0;
      rsp_valid           <= 1'b0;
      reservation_valid   <= 1'b0;
      reservation_address <= '0;
      reservation_double  <= 1'b0;
    end else begin
      // Drop a taken response unless a new one loads on the same edge.
      if (rsp_valid && rsp_ready && !finish) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          // Sweep the store one entry a cycle.
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(MEM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            cur   <= req;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (finish) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            if (resv_clear) begin
              reservation_valid <= 1'b0;
            end else if (resv_set) begin
              reservation_valid   <= 1'b1;
              reservation_address <= cur.address;
              reservation_double  <= cur.is_double;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      atomics_enable             <= 1'b1;
      doubleword_enable          <= 1'b1;
      misaligned_as_access_fault <= 1'b0;
      local_only                 <= 1'b0;
      local_base                 <= '0;
      local_limit                <= '1;
    end else if (cfg_write) begin
      case (paddr[4:2])
        amou_pkg::REG_ATOMICS_ENABLE:    atomics_enable             <= pwdata[0];
        amou_pkg::REG_DOUBLEWORD_ENABLE: doubleword_enable          <= pwdata[0];
        amou_pkg::REG_MISALIGNED_AS_AF:  misaligned_as_access_fault <= pwdata[0];
        amou_pkg::REG_LOCAL_ONLY:        local_only                 <= pwdata[0];
        amou_pkg::REG_LOCAL_BASE:        local_base  <= pwdata[amou_pkg::ADDR_W-1:0];
        amou_pkg::REG_LOCAL_LIMIT:       local_limit <= pwdata[amou_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      amou_pkg::REG_ATOMICS_ENABLE:    prdata[0] = atomics_enable;
      amou_pkg::REG_DOUBLEWORD_ENABLE: prdata[0] = doubleword_enable;
      amou_pkg::REG_MISALIGNED_AS_AF:  prdata[0] = misaligned_as_access_fault;
      amou_pkg::REG_LOCAL_ONLY:        prdata[0] = local_only;
      amou_pkg::REG_LOCAL_BASE:        prdata[amou_pkg::ADDR_W-1:0] = local_base;
      amou_pkg::REG_LOCAL_LIMIT:       prdata[amou_pkg::ADDR_W-1:0] = local_limit;
      default:                         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/amou_checker.sv =====
module amou_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input amou_pkg::amou_rsp_t rsp,
  input logic                pready
);

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // A faulting request never writes rd and returns zero.
  a_fault_no_rd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.fault != amou_pkg::FAULT_NONE) |-> !rsp.rd_written && (rsp.rd_value == '0))
    else $error("faulting request wrote rd");

  // A clean request always writes rd.
  a_clean_rd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.fault == amou_pkg::FAULT_NONE) |-> rsp.rd_written)
    else $error("clean request did not write rd");

  // One request at a time: no accept in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind atomic_memory_op_unit amou_checker u_amou_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp),
  .pready    (pready)
);
